/* rtl/csl_pkg.sv */
// Shared types, constants and character helpers for the C subset lexer.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package csl_pkg;

    localparam int POS_BITS   = 16;
    localparam int KW_LIMIT   = 6;
    localparam int KW_IDX_BITS = $clog2(KW_LIMIT);
    localparam int KW_COUNT   = 8;
    localparam int KW_MAX     = 6;
    localparam int MAX_RES    = 3;
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = $clog2(QDEPTH);
    localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

    localparam logic [63:0] ACC_LIMIT = 64'd1844674407370955161;
    localparam logic [63:0] ACC_LAST  = 64'd5;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        M_IDLE   = 3'd0,
        M_NUM    = 3'd1,
        M_IDENT  = 3'd2,
        M_HELD   = 3'd3,
        M_STR    = 3'd4,
        M_ESC    = 3'd5,
        M_IGNORE = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        K_NUMBER  = 3'd0,
        K_IDENT   = 3'd1,
        K_KEYWORD = 3'd2,
        K_PUNCT   = 3'd3,
        K_STRING  = 3'd4,
        K_SBYTE   = 3'd5,
        K_END     = 3'd6,
        K_ERROR   = 3'd7
    } kind_t;

    typedef logic [KW_LIMIT-1:0][7:0] prefix_t;
    typedef logic [KW_MAX-1:0][7:0]   kw_text_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [63:0] value;
    } result_t;

    typedef struct packed {
        logic [1:0]                cnt;
        result_t [MAX_RES-1:0]     res;
    } bundle_t;

    function automatic logic is_digit(logic [7:0] b);
        return b inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return b inside {["a":"z"], ["A":"Z"], "_"};
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return b inside {" ", [8'd9:8'd13]};
    endfunction

    function automatic logic is_punct(logic [7:0] b);
        return (b inside {[8'd33:8'd126]}) && !is_alpha(b) && !is_digit(b) && (b != "\"");
    endfunction

    function automatic logic [7:0] unescape(logic [7:0] b);
        logic [7:0] r;
        case (b)
            "a":     r = 8'd7;
            "b":     r = 8'd8;
            "t":     r = 8'd9;
            "n":     r = 8'd10;
            "v":     r = 8'd11;
            "f":     r = 8'd12;
            "r":     r = 8'd13;
            "e":     r = 8'd27;
            default: r = b;
        endcase
        return r;
    endfunction

    function automatic kw_text_t kw_text(logic [2:0] i);
        kw_text_t t;
        case (i)
            3'd0:    t = {"n", "r", "u", "t", "e", "r"};
            3'd1:    t = {8'h00, 8'h00, 8'h00, 8'h00, "f", "i"};
            3'd2:    t = {8'h00, 8'h00, "e", "s", "l", "e"};
            3'd3:    t = {8'h00, 8'h00, 8'h00, "r", "o", "f"};
            3'd4:    t = {8'h00, "e", "l", "i", "h", "w"};
            3'd5:    t = {8'h00, 8'h00, 8'h00, "t", "n", "i"};
            3'd6:    t = {"f", "o", "e", "z", "i", "s"};
            default: t = {8'h00, 8'h00, "r", "a", "h", "c"};
        endcase
        return t;
    endfunction

    function automatic logic [15:0] kw_len(logic [2:0] i);
        logic [15:0] l;
        case (i)
            3'd0:    l = 16'd6;
            3'd1:    l = 16'd2;
            3'd2:    l = 16'd4;
            3'd3:    l = 16'd3;
            3'd4:    l = 16'd5;
            3'd5:    l = 16'd3;
            3'd6:    l = 16'd6;
            default: l = 16'd4;
        endcase
        return l;
    endfunction

    // returns {hit, index}
    function automatic logic [3:0] keyword_match(prefix_t pre, logic [15:0] len);
        logic       hit;
        logic [2:0] idx;
        logic       ok;
        kw_text_t   t;
        logic [15:0] kl;
        hit = 1'b0;
        idx = 3'd0;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            t  = kw_text(3'(i));
            kl = kw_len(3'(i));
            ok = (len == kl) && (kl <= 16'(KW_LIMIT));
            for (int j = 0; j < KW_MAX; j++)
            begin
                if ((16'(j) < kl) && (pre[j] != t[j]))
                begin
                    ok = 1'b0;
                end
            end
            if (ok && !hit)
            begin
                hit = 1'b1;
                idx = 3'(i);
            end
        end
        return {hit, idx};
    endfunction

    function automatic bundle_t add_res(bundle_t bd, kind_t k, logic [15:0] s,
                                        logic [15:0] l, logic [63:0] v);
        bundle_t r;
        r = bd;
        r.res[r.cnt].kind  = k;
        r.res[r.cnt].start = s;
        r.res[r.cnt].len   = l;
        r.res[r.cnt].value = v;
        r.cnt = r.cnt + 2'd1;
        return r;
    endfunction

    function automatic bundle_t add_name(bundle_t bd, prefix_t pre, logic [15:0] s,
                                         logic [15:0] l);
        logic [3:0] m;
        m = keyword_match(pre, l);
        if (m[3])
        begin
            return add_res(bd, K_KEYWORD, s, l, {61'd0, m[2:0]});
        end
        return add_res(bd, K_IDENT, s, l, 64'd0);
    endfunction

endpackage
`default_nettype wire

/* rtl/csl_front.sv */
// Front end: takes one text byte a cycle on accept, classifies it, updates
// lexer state and produces a bundle of up to three results. Depends on csl_pkg.
`default_nettype none
module csl_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      text_byte,
    input  wire logic            end_of_text,
    output logic                 q_push,
    output csl_pkg::bundle_t     q_data
);
    import csl_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] ts_reg, ts_next;
    logic [63:0] acc_reg, acc_next;
    prefix_t     pre_reg, pre_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] dc_reg, dc_next;
    bundle_t     bd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            pos_reg  <= '0;
            ts_reg   <= '0;
            acc_reg  <= '0;
            pre_reg  <= '0;
            held_reg <= '0;
            dc_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            ts_reg   <= ts_next;
            acc_reg  <= acc_next;
            pre_reg  <= pre_next;
            held_reg <= held_next;
            dc_reg   <= dc_next;
        end
    end

    always_comb
    begin
        logic        idle_start;
        logic        failed;
        logic [15:0] span;
        logic [7:0]  b;
        logic [63:0] d;
        b          = text_byte;
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        ts_next    = ts_reg;
        acc_next   = acc_reg;
        pre_next   = pre_reg;
        held_next  = held_reg;
        dc_next    = dc_reg;
        bd         = '0;
        idle_start = 1'b0;
        failed     = 1'b0;
        span       = pos_reg - ts_reg;
        d          = {56'd0, b - 8'd48};
        if (b != 8'd0)
        begin
            case (mode_reg)
                M_NUM:
                begin
                    if (is_digit(b))
                    begin
                        if ((acc_reg > ACC_LIMIT) || ((acc_reg == ACC_LIMIT) && (d > ACC_LAST)))
                        begin
                            acc_next = '1;
                        end
                        else
                        begin
                            acc_next = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0} + d;
                        end
                    end
                    else
                    begin
                        bd = add_res(bd, K_NUMBER, ts_reg, span, acc_reg);
                        mode_next  = M_IDLE;
                        idle_start = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_alpha(b) || is_digit(b))
                    begin
                        if (span < 16'(KW_LIMIT))
                        begin
                            pre_next[span[KW_IDX_BITS-1:0]] = b;
                        end
                    end
                    else
                    begin
                        bd = add_name(bd, pre_reg, ts_reg, span);
                        mode_next  = M_IDLE;
                        idle_start = 1'b1;
                    end
                end
                M_HELD:
                begin
                    mode_next = M_IDLE;
                    if (b == "=")
                    begin
                        bd = add_res(bd, K_PUNCT, ts_reg, 16'd2, {48'd0, 8'("="), held_reg});
                    end
                    else
                    begin
                        bd = add_res(bd, K_PUNCT, ts_reg, 16'd1, {56'd0, held_reg});
                        idle_start = 1'b1;
                    end
                end
                M_STR:
                begin
                    if (b == "\"")
                    begin
                        bd = add_res(bd, K_STRING, ts_reg, span + 16'd1, {48'd0, dc_reg});
                        mode_next = M_IDLE;
                    end
                    else if (b == 8'd10)
                    begin
                        bd = add_res(bd, K_ERROR, ts_reg, span, 64'd0);
                        mode_next = M_IGNORE;
                    end
                    else if (b == "\\")
                    begin
                        mode_next = M_ESC;
                    end
                    else
                    begin
                        bd = add_res(bd, K_SBYTE, pos_reg, 16'd1, {56'd0, b});
                        if (dc_reg != COUNT_MAX)
                        begin
                            dc_next = dc_reg + 16'd1;
                        end
                    end
                end
                M_ESC:
                begin
                    bd = add_res(bd, K_SBYTE, pos_reg - 16'd1, 16'd2, {56'd0, unescape(b)});
                    if (dc_reg != COUNT_MAX)
                    begin
                        dc_next = dc_reg + 16'd1;
                    end
                    mode_next = M_STR;
                end
                M_IGNORE:
                begin
                end
                default:
                begin
                    mode_next  = M_IDLE;
                    idle_start = 1'b1;
                end
            endcase
            if (idle_start && !is_space(b))
            begin
                ts_next = pos_reg;
                if (is_digit(b))
                begin
                    mode_next = M_NUM;
                    acc_next  = d;
                end
                else if (b == "\"")
                begin
                    mode_next = M_STR;
                    dc_next   = '0;
                end
                else if (is_alpha(b))
                begin
                    mode_next   = M_IDENT;
                    pre_next    = '0;
                    pre_next[0] = b;
                end
                else if ((b == "=") || (b == "!") || (b == "<") || (b == ">"))
                begin
                    mode_next = M_HELD;
                    held_next = b;
                end
                else if (is_punct(b))
                begin
                    bd = add_res(bd, K_PUNCT, pos_reg, 16'd1, {56'd0, b});
                end
                else
                begin
                    bd = add_res(bd, K_ERROR, pos_reg, 16'd1, 64'd0);
                    mode_next = M_IGNORE;
                end
            end
            pos_next = pos_reg + 16'd1;
        end
        if ((b == 8'd0) || end_of_text)
        begin
            span = pos_next - ts_next;
            case (mode_next)
                M_NUM:    bd = add_res(bd, K_NUMBER, ts_next, span, acc_next);
                M_IDENT:  bd = add_name(bd, pre_next, ts_next, span);
                M_HELD:   bd = add_res(bd, K_PUNCT, ts_next, 16'd1, {56'd0, held_next});
                M_STR, M_ESC:
                begin
                    bd = add_res(bd, K_ERROR, ts_next, span, 64'd0);
                    failed = 1'b1;
                end
                M_IGNORE: failed = 1'b1;
                default:  failed = 1'b0;
            endcase
            if (!failed)
            begin
                bd = add_res(bd, K_END, pos_next, 16'd0, 64'd0);
            end
            mode_next = M_IDLE;
            pos_next  = '0;
            ts_next   = '0;
        end
    end

    assign q_push = accept && (bd.cnt != 2'd0);
    assign q_data = bd;

endmodule
`default_nettype wire

/* rtl/csl_queue.sv */
// Short bundle queue between the front end and the result stage.
// Depends on csl_pkg for the bundle type and depth.
`default_nettype none
module csl_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire csl_pkg::bundle_t wdata,
    output logic                  full,
    input  wire logic             pop,
    output csl_pkg::bundle_t      rdata,
    output logic                  empty
);
    import csl_pkg::*;

    bundle_t                mem [QDEPTH];
    logic [QPTR_BITS-1:0]   wr_reg, rd_reg;
    logic [QCNT_BITS-1:0]   cnt_reg;
    logic                   do_push, do_pop;

    assign full    = (cnt_reg == QCNT_BITS'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/csl_back.sv */
// Result stage: holds one bundle and hands out its results one item a cycle on pop.
// Depends on csl_pkg for the bundle and result types.
`default_nettype none
module csl_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_empty,
    input  wire csl_pkg::bundle_t q_data,
    output logic                  q_pop,
    output logic                  empty,
    input  wire logic             pop,
    output logic [2:0]            token_kind,
    output logic [15:0]           start_offset,
    output logic [15:0]           source_length,
    output logic [63:0]           token_value,
    output logic                  last_of_run
);
    import csl_pkg::*;

    bundle_t    cur_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       is_last;
    logic       take;
    result_t    cur;

    assign cur           = cur_reg.res[idx_reg];
    assign is_last       = (idx_reg == (cur_reg.cnt - 2'd1));
    assign take          = !valid_reg || (pop && is_last);
    assign q_pop         = take && !q_empty;
    assign empty         = !valid_reg;
    assign token_kind    = cur.kind;
    assign start_offset  = cur.start;
    assign source_length = cur.len;
    assign token_value   = cur.value;
    assign last_of_run   = is_last;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (take)
        begin
            valid_reg <= !q_empty;
            idx_reg   <= '0;
        end
        else if (pop)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule
`default_nettype wire

/* rtl/c_subset_lexer_top.sv */
// Top level of the C subset lexer: front end, bundle queue and result stage.
// Depends on csl_pkg, csl_front, csl_queue and csl_back.
`default_nettype none
// The lexer takes one source byte per cycle and produces number, identifier,
// keyword, punctuator, string, string byte, end and error items. Each byte is
// classified and folded into the lexer state in the cycle it is accepted; the
// zero to three results it causes go as one group into a four-deep queue, and
// the output stage hands out one result a cycle on pop. Text in which each
// byte causes at most one result runs at one byte per cycle; bytes that cause
// two or three results fill the queue, and full then holds input until the
// output side has drained them. No clearing pass runs after reset.
module c_subset_lexer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  text_byte,
    input  wire logic        end_of_text,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       token_kind,
    output logic [15:0]      start_offset,
    output logic [15:0]      source_length,
    output logic [63:0]      token_value,
    output logic             last_of_run
);
    import csl_pkg::*;

    logic    accept;
    logic    f_push;
    bundle_t f_data;
    logic    q_full, q_empty, q_pop;
    bundle_t q_data;

    assign full   = q_full;
    assign accept = push && !q_full;

    csl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .q_push      (f_push),
        .q_data      (f_data)
    );

    csl_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .wdata (f_data),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_data),
        .empty (q_empty)
    );

    csl_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .token_kind    (token_kind),
        .start_offset  (start_offset),
        .source_length (source_length),
        .token_value   (token_value),
        .last_of_run   (last_of_run)
    );

endmodule
`default_nettype wire
